/* rtl/vuq_pkg.sv */
// ----------------------------------------------------------------------------
// vuq_pkg
// Shared types and constants for the value unescape decoder.
// ----------------------------------------------------------------------------
package vuq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [7:0] data;
      logic       byte_valid;
      logic       value_end;
      logic       line_end;
   } result_type;

   typedef struct packed {
      result_type res0;
      result_type res1;
      logic       has_second;
   } cmd_type;

endpackage

/* rtl/vcard_value_unescape_decoder_top.sv */
// ----------------------------------------------------------------------------
// vcard_value_unescape_decoder_top
// Value-part decoder for a contact-card content line: quoted-printable and
// backslash unescaping, value and line end marking.
//
// Usage:
//   req_* carries one raw byte per item with the quoted-printable flag and
//   an end-of-text flag. rsp_* gives decoded results: a byte, a value end,
//   a line end, and run_last on the final result of each item.
//   An item gives zero, one or two results.
//   Path: an accepted item's command is written to the queue at the
//   accepting edge and then moves to the output register that drives
//   rsp_valid.
//   Throughput: one item per cycle while the queue is not full; the back
//   drains one result per cycle while rsp_ready is high, so an item with
//   two results is sent as two separate results. The command queue (QUEUE_DEPTH entries) absorbs this.
//   Reset: synchronous; clears the decode phase, the queue and the output.
//   Stall: while rsp_ready is low the output holds; req_ready drops once
//   the queue fills.
// ----------------------------------------------------------------------------
module vcard_value_unescape_decoder_top
   import vuq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_qp_enable,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_value_end,
   output logic       rsp_line_end,
   output logic       rsp_run_last
);

   logic    q_full, q_push, q_pop, q_head_valid;
   cmd_type q_push_data, q_head_data;

   vuq_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_qp_enable   (req_qp_enable),
      .req_end_of_text (req_end_of_text),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_push_data     (q_push_data)
   );

   vuq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   vuq_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (q_head_valid),
      .head_data      (q_head_data),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_value_end  (rsp_value_end),
      .rsp_line_end   (rsp_line_end),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

/* rtl/vuq_front.sv */
// ----------------------------------------------------------------------------
// vuq_front
// Accepts input items, tracks the decode phase and turns each item into a
// queue command of zero, one or two results.
// ----------------------------------------------------------------------------
module vuq_front
   import vuq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_qp_enable,
   input  logic       req_end_of_text,
   input  logic       q_full,
   output logic       q_push,
   output cmd_type    q_push_data
);

   localparam logic [2:0] PH_NORMAL = 3'd0;
   localparam logic [2:0] PH_QP_A   = 3'd1;
   localparam logic [2:0] PH_QP_B   = 3'd2;
   localparam logic [2:0] PH_ESC    = 3'd3;
   localparam logic [2:0] PH_SKIP   = 3'd4;

   localparam logic [7:0] CH_EQ   = 8'h3D;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_BSL  = 8'h5C;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_N    = 8'h6E;
   localparam logic [7:0] CH_R    = 8'h72;
   localparam logic [7:0] NIB_MASK = 8'h0F;

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] v;
      v = c;
      if (v >= 8'h41 && v <= 8'h5A) begin
         v = v + 8'h20;
      end
      if (v >= 8'h61) begin
         v = v - 8'h61 + 8'd10;
      end else begin
         v = v - 8'h30;
      end
      v = v & NIB_MASK;
      return v[3:0];
   endfunction

   function automatic result_type mk(input logic [7:0] d, input logic bv,
                                     input logic ve, input logic le);
      result_type r;
      r.data       = bv ? d : 8'h00;
      r.byte_valid = bv;
      r.value_end  = ve;
      r.line_end   = le;
      return r;
   endfunction

   logic [2:0] phase_ff, phase_in;
   logic [7:0] first_ff, first_in;
   logic       take;
   logic       has_result;
   cmd_type    cmd;

   assign req_ready = !q_full;
   assign take      = req_valid && req_ready;

   always_comb begin
      phase_in   = phase_ff;
      first_in   = first_ff;
      has_result = 1'b0;
      cmd        = '0;
      unique case (phase_ff)
         PH_QP_A: begin
            if (req_end_of_text) begin
               cmd.res0   = mk(8'h00, 1'b0, 1'b1, 1'b1);
               has_result = 1'b1;
               phase_in   = PH_NORMAL;
            end else begin
               first_in = req_data_byte;
               phase_in = PH_QP_B;
            end
         end
         PH_QP_B: begin
            phase_in = PH_NORMAL;
            if (req_end_of_text) begin
               cmd.res0   = mk(8'h00, 1'b0, 1'b1, 1'b1);
               has_result = 1'b1;
            end else if (first_ff == CH_CR && req_data_byte == CH_LF) begin
               has_result = 1'b0;
            end else if (is_alnum(first_ff) && is_alnum(req_data_byte)) begin
               cmd.res0   = mk({nibble_of(first_ff), nibble_of(req_data_byte)},
                               1'b1, 1'b0, 1'b0);
               has_result = 1'b1;
            end
         end
         PH_ESC: begin
            phase_in   = PH_NORMAL;
            has_result = 1'b1;
            if (req_end_of_text) begin
               cmd.res0       = mk(CH_BSL, 1'b1, 1'b0, 1'b0);
               cmd.res1       = mk(8'h00, 1'b0, 1'b1, 1'b1);
               cmd.has_second = 1'b1;
            end else if (req_data_byte == CH_N) begin
               cmd.res0 = mk(CH_LF, 1'b1, 1'b0, 1'b0);
            end else if (req_data_byte == CH_R) begin
               cmd.res0 = mk(CH_CR, 1'b1, 1'b0, 1'b0);
            end else if (req_data_byte == CH_SEMI || req_data_byte == CH_COMMA ||
                         req_data_byte == CH_BSL) begin
               cmd.res0 = mk(req_data_byte, 1'b1, 1'b0, 1'b0);
            end else begin
               cmd.res0       = mk(CH_BSL, 1'b1, 1'b0, 1'b0);
               cmd.res1       = mk(req_data_byte, 1'b1, 1'b0, 1'b0);
               cmd.has_second = 1'b1;
            end
         end
         PH_SKIP: begin
            phase_in = PH_NORMAL;
         end
         default: begin
            phase_in = PH_NORMAL;
            if (req_end_of_text) begin
               cmd.res0   = mk(8'h00, 1'b0, 1'b1, 1'b1);
               has_result = 1'b1;
            end else if (req_data_byte == CH_CR) begin
               cmd.res0   = mk(8'h00, 1'b0, 1'b1, 1'b1);
               has_result = 1'b1;
               phase_in   = PH_SKIP;
            end else if (req_data_byte == CH_EQ && req_qp_enable) begin
               phase_in = PH_QP_A;
            end else if (req_data_byte == CH_BSL) begin
               phase_in = PH_ESC;
            end else if (req_data_byte == CH_SEMI) begin
               cmd.res0   = mk(8'h00, 1'b0, 1'b1, 1'b0);
               has_result = 1'b1;
            end else begin
               cmd.res0   = mk(req_data_byte, 1'b1, 1'b0, 1'b0);
               has_result = 1'b1;
            end
         end
      endcase
   end

   assign q_push      = take && has_result;
   assign q_push_data = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NORMAL;
         first_ff <= 8'h00;
      end else if (take) begin
         phase_ff <= phase_in;
         first_ff <= first_in;
      end
   end

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_SKIP)
      else $error("decode phase out of range");

endmodule

/* rtl/vuq_queue.sv */
// ----------------------------------------------------------------------------
// vuq_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module vuq_queue
   import vuq_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count overflow");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push while queue full");

endmodule

/* rtl/vuq_back.sv */
// ----------------------------------------------------------------------------
// vuq_back
// Pops queue commands and sends their results, one per cycle while rsp_ready
// is high, through an output register.
// ----------------------------------------------------------------------------
module vuq_back
   import vuq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  cmd_type    head_data,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_value_end,
   output logic       rsp_line_end,
   output logic       rsp_run_last
);

   logic       valid_ff;
   logic       half_ff;
   result_type res_ff, res_in;
   logic       last_ff, last_in;
   logic       load;

   assign load    = !valid_ff || rsp_ready;
   assign res_in  = half_ff ? head_data.res1 : head_data.res0;
   assign last_in = half_ff || !head_data.has_second;
   assign pop     = load && head_valid && last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else if (load) begin
         valid_ff <= head_valid;
         if (head_valid) begin
            half_ff <= !last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && head_valid) begin
         res_ff  <= res_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = res_ff.data;
   assign rsp_byte_valid = res_ff.byte_valid;
   assign rsp_value_end  = res_ff.value_end;
   assign rsp_line_end   = res_ff.line_end;
   assign rsp_run_last   = last_ff;

   a_half_has_head: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> head_valid)
      else $error("second result pending without queue entry");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_ready && !last_ff) |=> valid_ff)
      else $error("second result of an item did not follow");

endmodule
